// ----- design/pid_filtered_derivative_integral_core_macros.svh -----
// assertion macros for the pid filtered derivative and integral core
// used by the top level only, no other dependencies
`ifndef PID_FILTERED_DERIVATIVE_INTEGRAL_CORE_MACROS_SVH
`define PID_FILTERED_DERIVATIVE_INTEGRAL_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PFDI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PFDI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pfdi_pkg.sv -----
// shared types and constants for the pid filtered derivative and integral core
// no dependencies
package pfdi_pkg;

  // default fraction bits of the q formats
  localparam int PFDI_FRAC_BITS = 16;
  // divisor width of the shared divider (gain or filter denominator)
  localparam int PFDI_DIVISOR_W = 32;
  // width of the signed numerator of the derivative filter
  localparam int PFDI_NUM_W = 51;
  // default dividend width of the shared divider
  localparam int PFDI_DIV_W = 51;

  // configuration register indexes
  localparam int PFDI_CFG_IDX_W = 3;
  localparam logic [PFDI_CFG_IDX_W-1:0] CFG_KI_DRIVE     = 3'd0;
  localparam logic [PFDI_CFG_IDX_W-1:0] CFG_KI_TURN      = 3'd1;
  localparam logic [PFDI_CFG_IDX_W-1:0] CFG_TC_DRIVE     = 3'd2;
  localparam logic [PFDI_CFG_IDX_W-1:0] CFG_TC_TURN      = 3'd3;
  localparam logic [PFDI_CFG_IDX_W-1:0] CFG_INTEGRAL_CAP = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_HIST,
    ST_MUL_DIFF,
    ST_MUL_INTEG,
    ST_DIV_DERIV,
    ST_DIV_LIM,
    ST_DONE
  } pfdi_state_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic ld_hist;
    logic ld_num;
    logic ld_integ;
    logic div_start;
    logic div_sel_lim;
    logic ld_deriv;
    logic ld_clamp;
    logic ld_out;
  } pfdi_ctl_t;

  // datapath to sequencer flags
  typedef struct packed {
    logic go;
    logic kind;
    logic den_zero;
    logic ki_zero;
    logic out_free;
  } pfdi_flags_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } pfdi_div_stat_t;

endpackage

// ----- design/pfdi_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on pfdi_pkg
module pfdi_div import pfdi_pkg::*; #(
  parameter int DVW = PFDI_DIV_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DVW-1:0]            dividend,
  input  logic [PFDI_DIVISOR_W-1:0] divisor,
  output logic [DVW-1:0]            quotient,
  output pfdi_div_stat_t            stat
);

  localparam int DSW = PFDI_DIVISOR_W;
  localparam int CW  = (DVW > 1) ? $clog2(DVW) : 1;

  logic [DVW-1:0] quo;
  logic [DSW-1:0] rem;
  logic [DSW-1:0] dsr;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic           done;
  logic [DSW:0]   rem_sh;
  logic [DSW+1:0] trial;

  // shift in next dividend bit and try the subtraction
  assign rem_sh = {rem, quo[DVW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dsr};

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - CW'(1);
      end
    end
  end

  // quotient and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[DSW+1]) begin
        rem <= trial[DSW-1:0];
        quo <= {quo[DVW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DSW-1:0];
        quo <= {quo[DVW-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- design/pfdi_ctrl.sv -----
// step sequencer: multiplies, then any derivative and limit divisions
// depends on pfdi_pkg
module pfdi_ctrl import pfdi_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  pfdi_flags_t    flags,
  input  pfdi_div_stat_t div_stat,
  output pfdi_ctl_t      ctl,
  output pfdi_state_t    state
);

  pfdi_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (flags.go) begin
          state_next = flags.kind ? ST_DONE : ST_MUL_HIST;
        end
      end
      ST_MUL_HIST:  state_next = ST_MUL_DIFF;
      ST_MUL_DIFF:  state_next = ST_MUL_INTEG;
      ST_MUL_INTEG: begin
        if (!flags.den_zero) begin
          state_next = ST_DIV_DERIV;
        end else begin
          state_next = flags.ki_zero ? ST_DONE : ST_DIV_LIM;
        end
      end
      ST_DIV_DERIV: begin
        if (div_stat.done) begin
          state_next = flags.ki_zero ? ST_DONE : ST_DIV_LIM;
        end
      end
      ST_DIV_LIM: begin
        if (div_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (flags.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    ctl = '0;
    case (state)
      ST_MUL_HIST: ctl.ld_hist = 1'b1;
      ST_MUL_DIFF: ctl.ld_num  = 1'b1;
      ST_MUL_INTEG: begin
        ctl.ld_integ    = 1'b1;
        ctl.div_start   = !flags.den_zero || !flags.ki_zero;
        ctl.div_sel_lim = flags.den_zero;
        ctl.ld_deriv    = flags.den_zero;
      end
      ST_DIV_DERIV: begin
        ctl.ld_deriv    = div_stat.done;
        ctl.div_start   = div_stat.done && !flags.ki_zero;
        ctl.div_sel_lim = 1'b1;
      end
      ST_DIV_LIM: ctl.ld_clamp = div_stat.done;
      ST_DONE:    ctl.ld_out   = flags.out_free;
      default:    ctl = '0;
    endcase
  end

endmodule

// ----- design/pid_filtered_derivative_integral_core.sv -----
// pid integral and filtered derivative core, top level; depends on pfdi_pkg,
// pfdi_div, pfdi_ctrl and the assertion macro header
// an update word runs the history, difference and integral multiply steps, then up to
// two divisions (derivative, limit) on the shared divider; a reset word skips them all
// a new word is accepted only once the previous result has been handed to the output
// reset: synchronous; clears state, integral, gains and time constants, cap all ones
`include "pid_filtered_derivative_integral_core_macros.svh"
module pid_filtered_derivative_integral_core import pfdi_pkg::*; #(
  parameter int FRAC_BITS = PFDI_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [PFDI_CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic                      loop_sel,
  input  logic signed [31:0]        err_sample,
  input  logic [15:0]               elapsed_ms,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        deriv_out,
  output logic signed [47:0]        integ_out,
  output logic                      clamped
);

  localparam int DVW = (32 + FRAC_BITS > PFDI_DIV_W) ? 32 + FRAC_BITS : PFDI_DIV_W;
  localparam int NW  = PFDI_NUM_W;
  localparam logic [47:0] I48_MAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] I48_MIN = {1'b1, {47{1'b0}}};
  localparam logic [31:0] I32_MAX = {1'b0, {31{1'b1}}};
  localparam logic [31:0] I32_MIN = {1'b1, {31{1'b0}}};

  // configuration registers
  logic [31:0] ki_drive;
  logic [31:0] ki_turn;
  logic [15:0] tc_drive;
  logic [15:0] tc_turn;
  logic [31:0] integral_cap;

  // loop state
  logic signed [31:0] last_error;
  logic signed [31:0] last_deriv;
  logic signed [47:0] integ_acc;

  // captured word and working registers
  logic               kind_r;
  logic               sel_r;
  logic signed [31:0] err_r;
  logic [15:0]        dt_r;
  logic signed [49:0] prod_r;
  logic [NW-1:0]      num_r;
  logic [47:0]        integ_new;
  logic [31:0]        deriv_r;
  logic               clamped_r;

  // sequencer and divider hookup
  pfdi_ctl_t      ctl;
  pfdi_flags_t    flags;
  pfdi_div_stat_t div_stat;
  pfdi_state_t    state;
  logic [DVW-1:0] div_dividend;
  logic [31:0]    div_divisor;
  logic [DVW-1:0] quotient;

  // datapath nets
  logic [31:0]        ki_sel;
  logic [15:0]        tc_sel;
  logic [16:0]        den;
  logic signed [32:0] diff;
  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [49:0] mul_p;
  logic [48:0]        integ_sum;
  logic [47:0]        integ_sat;
  logic [NW-1:0]      num_mag;
  logic               num_neg;
  logic [31:0]        deriv_val;
  logic [47:0]        amag;
  logic [47:0]        clamp_mag;
  logic               in_go;
  logic               out_free;

  // input held off while in reset or busy with a word
  assign in_go    = in_valid && !in_stall;
  assign in_stall = rst || (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ki_drive     <= '0;
      ki_turn      <= '0;
      tc_drive     <= '0;
      tc_turn      <= '0;
      integral_cap <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KI_DRIVE:     ki_drive     <= cfg_data;
        CFG_KI_TURN:      ki_turn      <= cfg_data;
        CFG_TC_DRIVE:     tc_drive     <= cfg_data[15:0];
        CFG_TC_TURN:      tc_turn      <= cfg_data[15:0];
        CFG_INTEGRAL_CAP: integral_cap <= cfg_data;
        default: ;
      endcase
    end
  end

  // gain set selection and filter denominator
  assign ki_sel = sel_r ? ki_turn : ki_drive;
  assign tc_sel = sel_r ? tc_turn : tc_drive;
  assign den    = {1'b0, tc_sel} + {1'b0, dt_r};
  assign diff   = {err_r[31], err_r} - {last_error[31], last_error};

  // shared multiplier, operands picked by step
  always_comb begin
    if (ctl.ld_hist) begin
      mul_a = {1'b0, tc_sel};
      mul_b = {last_deriv[31], last_deriv};
    end else if (ctl.ld_num) begin
      mul_a = {1'b0, dt_r};
      mul_b = diff;
    end else begin
      mul_a = {1'b0, dt_r};
      mul_b = {err_r[31], err_r};
    end
  end
  assign mul_p = mul_a * mul_b;

  // integral sum with 48 bit saturation
  assign integ_sum = {integ_acc[47], integ_acc} + {mul_p[47], mul_p[47:0]};
  always_comb begin
    if (integ_sum[48] != integ_sum[47]) begin
      integ_sat = integ_sum[48] ? I48_MIN : I48_MAX;
    end else begin
      integ_sat = integ_sum[47:0];
    end
  end

  // numerator magnitude for the derivative division
  assign num_neg = num_r[NW-1];
  assign num_mag = num_neg ? (~num_r + NW'(1)) : num_r;

  // divider operands: rounded derivative or integral limit
  always_comb begin
    if (ctl.div_sel_lim) begin
      div_dividend = DVW'({integral_cap, {FRAC_BITS{1'b0}}});
      div_divisor  = ki_sel;
    end else begin
      div_dividend = DVW'(num_mag) + DVW'(den[16:1]);
      div_divisor  = 32'(den);
    end
  end

  // derivative value: raw difference when denominator is zero, else signed quotient
  always_comb begin
    if (flags.den_zero) begin
      if (diff[32] != diff[31]) begin
        deriv_val = diff[32] ? I32_MIN : I32_MAX;
      end else begin
        deriv_val = diff[31:0];
      end
    end else if (!num_neg) begin
      deriv_val = (quotient[DVW-1:31] != '0) ? I32_MAX : quotient[31:0];
    end else if ((quotient[DVW-1:32] != '0) || (quotient[31] && (quotient[30:0] != '0))) begin
      deriv_val = I32_MIN;
    end else begin
      deriv_val = ~quotient[31:0] + 32'd1;
    end
  end

  // clamp magnitude and integral magnitude
  assign amag      = integ_new[47] ? (~integ_new + 48'd1) : integ_new;
  assign clamp_mag = (quotient > DVW'(I48_MAX)) ? I48_MAX : quotient[47:0];

  // working registers
  always_ff @(posedge clk) begin
    if (in_go) begin
      kind_r    <= kind;
      sel_r     <= loop_sel;
      err_r     <= err_sample;
      dt_r      <= elapsed_ms;
      clamped_r <= 1'b0;
    end
    if (ctl.ld_hist) begin
      prod_r <= mul_p;
    end
    if (ctl.ld_num) begin
      num_r <= {prod_r[49], prod_r} + {mul_p[49], mul_p};
    end
    if (ctl.ld_integ) begin
      integ_new <= integ_sat;
    end
    if (ctl.ld_deriv) begin
      deriv_r <= deriv_val;
    end
    if (ctl.ld_clamp && ({{(DVW-48){1'b0}}, amag} > quotient)) begin
      clamped_r <= 1'b1;
      if (err_r > 0) begin
        integ_new <= clamp_mag;
      end else if (err_r < 0) begin
        integ_new <= ~clamp_mag + 48'd1;
      end else begin
        integ_new <= '0;
      end
    end
  end

  // loop state update at the end of each word
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      last_deriv <= '0;
      integ_acc  <= '0;
    end else if (ctl.ld_out) begin
      if (kind_r) begin
        last_error <= '0;
        integ_acc  <= '0;
      end else begin
        last_error <= err_r;
        last_deriv <= deriv_r;
        integ_acc  <= integ_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      deriv_out <= kind_r ? last_deriv : deriv_r;
      integ_out <= kind_r ? '0 : integ_new;
      clamped   <= kind_r ? 1'b0 : clamped_r;
    end
  end

  // sequencer flags
  assign flags.go       = in_go;
  assign flags.kind     = kind;
  assign flags.den_zero = (den == '0);
  assign flags.ki_zero  = (ki_sel == '0);
  assign flags.out_free = out_free;

  pfdi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .div_stat (div_stat),
    .ctl      (ctl),
    .state    (state)
  );

  pfdi_div #(
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // an accepted word keeps the block busy in the next cycle
  `PFDI_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_go, in_stall, "not busy after accept")
  // the divider only runs in the division steps
  `PFDI_ASSERT_NOW(a_div_in_div_state, clk, rst, div_stat.busy, (state == ST_DIV_DERIV) || (state == ST_DIV_LIM), "divider busy outside division")
  // a clamp is only reported with a nonzero gain
  `PFDI_ASSERT_NOW(a_clamp_needs_gain, clk, rst, ctl.ld_out && !kind_r && clamped_r, ki_sel != '0, "clamp with zero gain")

endmodule

// ----- tb/pid_filtered_derivative_integral_core_tb.sv -----
`timescale 1ns / 100ps
// testbench for pid_filtered_derivative_integral_core: a directed table, then random words
// under several gain settings and handshake idling patterns, checked by predictor or table
// depends on pfdi_pkg and the core rtl
module pid_filtered_derivative_integral_core_tb;
  import pfdi_pkg::*;

  localparam int N_PHASES        = 9;
  localparam int WORDS_PER_PHASE = 210;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 150;

  localparam longint I48_HI = (longint'(1) << 47) - 1;
  localparam longint I48_LO = -(longint'(1) << 47);
  localparam longint I32_HI = (longint'(1) << 31) - 1;
  localparam longint I32_LO = -(longint'(1) << 31);

  // one input word
  typedef struct packed {
    logic        kind;
    logic        loop_sel;
    logic [31:0] err;
    logic [15:0] dt;
  } step_t;

  // one result word
  typedef struct packed {
    logic [31:0] deriv;
    logic [47:0] integ;
    logic        clamped;
  } loop_terms_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // directed table row: a register write or a word, with an optional hand-typed result
  typedef struct packed {
    row_kind_t                 what;
    logic [PFDI_CFG_IDX_W-1:0] reg_idx;
    logic [31:0]               reg_val;
    step_t                     w;
    logic                      known;
    loop_terms_t               terms;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [PFDI_CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]               cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      kind = 1'b0;
  logic                      loop_sel = 1'b0;
  logic signed [31:0]        err_sample = '0;
  logic [15:0]               elapsed_ms = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [31:0]        deriv_out;
  logic signed [47:0]        integ_out;
  logic                      clamped;

  // predictor copy of the registers and loop state
  logic [31:0] ki_drive_r = '0;
  logic [31:0] ki_turn_r  = '0;
  logic [15:0] tc_drive_r = '0;
  logic [15:0] tc_turn_r  = '0;
  logic [31:0] cap_r      = '1;
  longint      prev_error = 0;
  longint      prev_deriv = 0;
  longint      integ_sum  = 0;

  loop_terms_t pending_terms [$];
  int          fail_count = 0;
  int          n_sent = 0;
  int          n_resets = 0;
  int          n_checked = 0;
  int          n_clamped = 0;
  int          send_pct = 0;
  int          recv_pct = 0;
  int          hold_kick = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  pid_filtered_derivative_integral_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .loop_sel   (loop_sel),
    .err_sample (err_sample),
    .elapsed_ms (elapsed_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .deriv_out  (deriv_out),
    .integ_out  (integ_out),
    .clamped    (clamped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // filtered derivative, integral with anti-windup, state update
  function automatic loop_terms_t advance_loop(step_t w);
    loop_terms_t     r;
    longint          e, dt, tc, diff, den, num, d, cv;
    longint unsigned ki, mag, q, lim, amag;
    r = '0;
    if (w.kind) begin
      integ_sum  = 0;
      prev_error = 0;
      r.deriv    = prev_deriv[31:0];
      return r;
    end
    e    = $signed(w.err);
    dt   = w.dt;
    ki   = w.loop_sel ? ki_turn_r : ki_drive_r;
    tc   = w.loop_sel ? tc_turn_r : tc_drive_r;
    diff = e - prev_error;
    den  = tc + dt;
    // no time base at all: raw difference
    if (den == 0) begin
      d = clip(diff, I32_LO, I32_HI);
    end else begin
      num = tc * prev_deriv + dt * diff;
      mag = (num < 0) ? -num : num;
      q   = (mag + den / 2) / den;
      d   = clip((num < 0) ? -longint'(q) : longint'(q), I32_LO, I32_HI);
    end
    integ_sum = clip(integ_sum + e * dt, I48_LO, I48_HI);
    // exact clamp test against cap / ki
    if (ki != 0) begin
      lim  = (64'(cap_r) << PFDI_FRAC_BITS) / ki;
      amag = (integ_sum < 0) ? -integ_sum : integ_sum;
      if (amag > lim) begin
        cv        = (lim > I48_HI) ? I48_HI : longint'(lim);
        integ_sum = (e > 0) ? cv : ((e < 0) ? -cv : 0);
        r.clamped = 1'b1;
      end
    end
    prev_error = e;
    prev_deriv = d;
    r.deriv    = d[31:0];
    r.integ    = integ_sum[47:0];
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [PFDI_CFG_IDX_W-1:0] idx, logic [31:0] val);
    stim_row_t r;
    r         = '0;
    r.what    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t word_row(logic k, logic sel, logic [31:0] e, logic [15:0] t);
    stim_row_t r;
    r      = '0;
    r.what = ROW_WORD;
    r.w    = '{kind: k, loop_sel: sel, err: e, dt: t};
    return r;
  endfunction

  function automatic stim_row_t known_row(logic k, logic sel, logic [31:0] e, logic [15:0] t,
                                          logic [31:0] dv, logic [47:0] iv, logic cl);
    stim_row_t r;
    r       = word_row(k, sel, e, t);
    r.known = 1'b1;
    r.terms = '{deriv: dv, integ: iv, clamped: cl};
    return r;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 32'h3FFFF);
      1:       return $urandom;
      2:       return ($urandom_range(0, 3) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_tc();
    case ($urandom_range(0, 3))
      0:       return 32'h0;
      1:       return 32'hFFFF;
      2:       return $urandom_range(1, 100);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // register write, mirrored into the predictor
  task automatic write_reg(logic [PFDI_CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KI_DRIVE:     ki_drive_r = val;
      CFG_KI_TURN:      ki_turn_r  = val;
      CFG_TC_DRIVE:     tc_drive_r = val[15:0];
      CFG_TC_TURN:      tc_turn_r  = val[15:0];
      CFG_INTEGRAL_CAP: cap_r      = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one word after a random gap, then queue its expected result
  task automatic send_word(step_t w, logic known, loop_terms_t typed);
    loop_terms_t pred;
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= w.kind;
    loop_sel   <= w.loop_sel;
    err_sample <= w.err;
    elapsed_ms <= w.dt;
    do @(posedge clk); while (in_stall);
    pred = advance_loop(w);
    pending_terms.push_back(known ? typed : pred);
    n_sent++;
    if (w.kind) n_resets++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
  endtask

  // result checking and receiver stall
  always @(posedge clk) begin
    loop_terms_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_terms.size() == 0) begin
          $display("%0t: unexpected result word: deriv %h integ %h clamped %b",
                   $time, deriv_out, integ_out, clamped);
          fail_count++;
        end else begin
          want = pending_terms.pop_front();
          n_checked++;
          if (clamped) n_clamped++;
          if (deriv_out !== want.deriv) begin
            $display("%0t: deriv_out expected %h, got %h", $time, want.deriv, deriv_out);
            fail_count++;
          end
          if (integ_out !== want.integ) begin
            $display("%0t: integ_out expected %h, got %h", $time, want.integ, integ_out);
            fail_count++;
          end
          if (clamped !== want.clamped) begin
            $display("%0t: clamped expected %b, got %b", $time, want.clamped, clamped);
            fail_count++;
          end
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else if (hold_kick != hold_seen) begin
        hold_seen = hold_kick;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_pct);
      end
    end
  end

  initial begin
    stim_row_t                 directed [$];
    step_t                     w;
    logic [31:0]               ext;
    logic [PFDI_CFG_IDX_W-1:0] spare_idx;

    directed = '{
      // defaults: zero gains and time constants, zero elapsed time
      known_row(1'b0, 1'b0, 32'h7FFF_FFFF, 16'h0, 32'h7FFF_FFFF, 48'h0, 1'b0),
      known_row(1'b0, 1'b0, 32'h8000_0000, 16'h0, 32'h8000_0000, 48'h0, 1'b0),
      // integral reset keeps the derivative
      known_row(1'b1, 1'b1, 32'h1234_5678, 16'h04D2, 32'h8000_0000, 48'h0, 1'b0),
      // integral runs into both saturation limits
      word_row(1'b0, 1'b0, 32'h7FFF_FFFF, 16'hFFFF),
      word_row(1'b0, 1'b0, 32'h7FFF_FFFF, 16'hFFFF),
      word_row(1'b0, 1'b1, 32'h8000_0000, 16'hFFFF),
      word_row(1'b0, 1'b1, 32'h8000_0000, 16'hFFFF),
      word_row(1'b0, 1'b1, 32'h8000_0000, 16'hFFFF),
      word_row(1'b1, 1'b0, 32'h0, 16'h0),
      cfg_row(CFG_KI_DRIVE, 32'h0001_0000),
      cfg_row(CFG_INTEGRAL_CAP, 32'h0001_0000),
      cfg_row(CFG_TC_TURN, 32'hFFFF),
      cfg_row(CFG_KI_TURN, 32'hFFFF_FFFF),
      // unit gain and cap: clamp to +1.0, then to -1.0
      known_row(1'b0, 1'b0, 32'h0001_0000, 16'h2, 32'h0001_0000, 48'h0001_0000, 1'b1),
      word_row(1'b0, 1'b0, 32'hFFFF_0000, 16'h3),
      word_row(1'b0, 1'b0, 32'h0, 16'h0),
      // zero cap with zero error clamps to zero
      cfg_row(CFG_INTEGRAL_CAP, 32'h0),
      word_row(1'b0, 1'b0, 32'h0, 16'h1),
      // slow filter on the turn set
      word_row(1'b0, 1'b1, 32'h7FFF_FFFF, 16'h1),
      word_row(1'b0, 1'b1, 32'h8000_0000, 16'hFFFF),
      // tc of one with unit steps gives rounding halves
      cfg_row(CFG_TC_DRIVE, 32'h1),
      cfg_row(CFG_INTEGRAL_CAP, 32'hFFFF_FFFF),
      cfg_row(CFG_KI_DRIVE, 32'h1),
      cfg_row(CFG_INTEGRAL_CAP + 3'd1, 32'hFFFF_FFFF),
      word_row(1'b1, 1'b0, 32'h0, 16'h0),
      word_row(1'b0, 1'b0, 32'h0000_0001, 16'h1),
      word_row(1'b0, 1'b0, 32'hFFFF_FFFE, 16'h1),
      word_row(1'b0, 1'b0, 32'h0000_0003, 16'h1),
      word_row(1'b0, 1'b0, 32'hFFFF_FFFF, 16'h1),
      word_row(1'b0, 1'b0, 32'h7FFF_FFFF, 16'hFFFF),
      word_row(1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed[i]) begin
      if (directed[i].what == ROW_CFG) begin
        drain_results();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_word(directed[i].w, directed[i].known, directed[i].terms);
      end
    end

    // random phases: all-zero and all-ones settings first, then random ones
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      send_pct = (p % 4 == 1) ? 62 : ((p % 4 == 3) ? 15 : 0);
      recv_pct = (p % 4 == 2) ? 62 : ((p % 4 == 3) ? 15 : 0);
      ext = (p == 0) ? 32'h0 : 32'hFFFF_FFFF;
      write_reg(CFG_KI_DRIVE, (p < 2) ? ext : pick_gain());
      write_reg(CFG_KI_TURN, (p < 2) ? ext : pick_gain());
      write_reg(CFG_TC_DRIVE, (p < 2) ? ext : pick_tc());
      write_reg(CFG_TC_TURN, (p < 2) ? ext : pick_tc());
      write_reg(CFG_INTEGRAL_CAP,
                (p < 2) ? ext : (($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom));
      spare_idx = PFDI_CFG_IDX_W'(CFG_INTEGRAL_CAP + 1 + $urandom_range(0, 2));
      write_reg(spare_idx, $urandom);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (p == PRESSURE_PHASE && i % 50 == 10) hold_kick++;
        w.kind     = ($urandom_range(0, 19) == 0);
        w.loop_sel = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
          0:       w.err = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          1, 2:    w.err = $urandom_range(0, 32'h7FFFF) - 32'h40000;
          default: w.err = $urandom;
        endcase
        case ($urandom_range(0, 4))
          0:       w.dt = 16'h0;
          1:       w.dt = 16'hFFFF;
          2, 3:    w.dt = 16'($urandom_range(1, 40));
          default: w.dt = 16'($urandom_range(0, 65535));
        endcase
        send_word(w, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d words (%0d integral resets) over %0d gain settings and idling mixes",
             n_sent, n_resets, N_PHASES);
    $display("checked %0d results, %0d of them with the anti-windup clamp applied",
             n_checked, n_clamped);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // overall run limit
  initial begin
    #10_000_000;
    $display("timeout: %0d results still pending", pending_terms.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
